// File: design/gbs_pkg.sv
package gbs_pkg;

  // field widths fixed by the interface
  localparam int COORD_W    = 16;
  localparam int SIDE_W     = COORD_W + 1;
  localparam int AREA_W     = 2 * SIDE_W;
  localparam int UNION_W    = AREA_W + 1;
  localparam int THR_W      = 9;
  localparam int PROD_W     = THR_W + UNION_W;
  localparam int PRE_W      = 12;
  localparam int POST_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // one pixel in Q12.4
  localparam logic [SIDE_W-1:0] PIXEL_ONE = SIDE_W'(16);
  localparam logic [PRE_W-1:0]  SEEN_MAX  = {PRE_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(179);

  // default list capacity
  localparam int GBS_MAX_KEPT = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_PRE_LIMIT  = 2'd1,
    CFG_POST_LIMIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
    logic               last_box;
  } in_item_t;

  typedef struct packed {
    logic               kept;
    logic [COORD_W-1:0] out_left;
    logic [COORD_W-1:0] out_top;
    logic [COORD_W-1:0] out_right;
    logic [COORD_W-1:0] out_bottom;
    logic               end_of_set;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch a new box
    logic area_en;   // compute area of the new box
    logic rd_en;     // read one kept entry into the test pipeline
    logic wr_en;     // store the new box in the list
    logic out_load;  // load the result register
    logic out_keep;
    logic out_last;
  } gbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic suppress;
  } gbs_status_t;

endpackage

// File: design/gbs_datapath.sv
module gbs_datapath import gbs_pkg::*; #(
  parameter int MAX_KEPT = GBS_MAX_KEPT,
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbs_cmd_t         cmd_i,
  input  logic [THR_W-1:0] thr_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  in_item_t         in_data_i,
  output gbs_status_t      status_o,
  output out_item_t        out_data_o
);

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [AREA_W-1:0]  area;
  } entry_t;

  // inclusive side length, zero when inverted
  function automatic logic [SIDE_W-1:0] side_len(logic [COORD_W-1:0] lo,
                                                 logic [COORD_W-1:0] hi);
    logic [SIDE_W-1:0] top;
    top = {1'b0, hi} + PIXEL_ONE;
    return (top > {1'b0, lo}) ? (top - {1'b0, lo}) : '0;
  endfunction

  in_item_t          box_q;
  logic [SIDE_W-1:0] wb_q, hb_q;
  logic [AREA_W-1:0] area_b_q;
  entry_t            mem_q [MAX_KEPT];
  entry_t            rd_q;
  logic [5:1]        v_q;
  logic [SIDE_W-1:0] iw_q, ih_q;
  logic [AREA_W-1:0] ak1_q, ak2_q, inter2_q, inter3_q, inter4_q;
  logic [UNION_W-1:0] uni3_q;
  logic [PROD_W-1:0] prod4_q;
  logic              uz4_q;
  logic              suppress_q;
  out_item_t         out_q;

  logic [COORD_W-1:0] ix1, iy1, ix2, iy2;
  logic [PROD_W-1:0]  inter_sh;
  logic               hit;

  // new box and its sides
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      box_q <= in_data_i;
      wb_q  <= side_len(in_data_i.box_left, in_data_i.box_right);
      hb_q  <= side_len(in_data_i.box_top, in_data_i.box_bottom);
    end
    if (cmd_i.area_en) begin
      area_b_q <= wb_q * hb_q;
    end
  end

  // kept list, area stored with each box
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= '{left: box_q.box_left, top: box_q.box_top,
                            right: box_q.box_right, bottom: box_q.box_bottom,
                            area: area_b_q};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // intersection corners
  always_comb begin
    ix1 = (rd_q.left > box_q.box_left) ? rd_q.left : box_q.box_left;
    iy1 = (rd_q.top > box_q.box_top) ? rd_q.top : box_q.box_top;
    ix2 = (rd_q.right < box_q.box_right) ? rd_q.right : box_q.box_right;
    iy2 = (rd_q.bottom < box_q.box_bottom) ? rd_q.bottom : box_q.box_bottom;
  end

  // overlap test pipeline
  always_ff @(posedge clk_i) begin
    iw_q     <= side_len(ix1, ix2);
    ih_q     <= side_len(iy1, iy2);
    ak1_q    <= rd_q.area;
    inter2_q <= iw_q * ih_q;
    ak2_q    <= ak1_q;
    uni3_q   <= {1'b0, ak2_q} + {1'b0, area_b_q} - {1'b0, inter2_q};
    inter3_q <= inter2_q;
    prod4_q  <= PROD_W'(thr_i) * PROD_W'(uni3_q);
    uz4_q    <= (uni3_q == '0);
    inter4_q <= inter3_q;
  end

  // final compare: inter*256 >= threshold*union
  assign inter_sh = PROD_W'({inter4_q, 8'd0});
  assign hit      = v_q[5] && !uz4_q && (inter_sh >= prod4_q);

  // stage valids and sticky suppress flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= '0;
      suppress_q <= 1'b0;
    end else begin
      v_q <= {v_q[4:1], cmd_i.rd_en};
      if (cmd_i.load) begin
        suppress_q <= 1'b0;
      end else if (hit) begin
        suppress_q <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.kept       <= cmd_i.out_keep;
      out_q.out_left   <= cmd_i.out_keep ? box_q.box_left : '0;
      out_q.out_top    <= cmd_i.out_keep ? box_q.box_top : '0;
      out_q.out_right  <= cmd_i.out_keep ? box_q.box_right : '0;
      out_q.out_bottom <= cmd_i.out_keep ? box_q.box_bottom : '0;
      out_q.end_of_set <= cmd_i.out_last;
    end
  end

  assign status_o.pipe_busy = |v_q;
  assign status_o.suppress  = suppress_q;
  assign out_data_o         = out_q;

endmodule

// File: design/gbs_ctrl.sv
module gbs_ctrl import gbs_pkg::*; #(
  parameter int MAX_KEPT = GBS_MAX_KEPT,
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  gbs_status_t           status_i,
  output gbs_cmd_t              cmd_o,
  output logic [THR_W-1:0]      thr_o,
  output logic [AW-1:0]         rd_addr_o,
  output logic [AW-1:0]         wr_addr_o
);

  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int LW = (CW > POST_W) ? CW : POST_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [THR_W-1:0]  thr_q, thr_d;
  logic [PRE_W-1:0]  pre_q, pre_d;
  logic [POST_W-1:0] post_q, post_d;
  logic [PRE_W-1:0]  seen_q, seen_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              go_q, go_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;

  logic [LW-1:0] post_w, cnt_w, limit_w;
  logic          considered, keep, emit, leave;

  // effective post limit, saturated to capacity (zero also selects capacity)
  always_comb begin
    post_w  = LW'(post_q);
    cnt_w   = LW'(cnt_q);
    limit_w = (post_q == '0 || post_w > LW'(MAX_KEPT)) ? LW'(MAX_KEPT) : post_w;
  end

  assign considered = (pre_q == '0) || (seen_q < pre_q);
  assign keep       = go_q && !status_i.suppress;
  assign emit       = keep || last_q;
  assign leave      = !emit || !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    thr_d       = thr_q;
    pre_d       = pre_q;
    post_d      = post_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    go_d        = go_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_THRESHOLD:  thr_d  = cfg_data_i[THR_W-1:0];
        CFG_PRE_LIMIT:  pre_d  = cfg_data_i[PRE_W-1:0];
        CFG_POST_LIMIT: post_d = cfg_data_i[POST_W-1:0];
        default: ;
      endcase
    end

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          go_d       = considered && (cnt_w < limit_w);
          last_d     = in_last_i;
          if (seen_q != SEEN_MAX) begin
            seen_d = seen_q + 1'b1;
          end
          state_d = ST_AREA;
        end
      end
      ST_AREA: begin
        cmd_o.area_en = 1'b1;
        idx_d         = '0;
        state_d       = (go_q && cnt_q != '0) ? ST_SCAN : ST_FINISH;
      end
      // one kept entry issued per cycle, stop early once suppressed
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + 1'b1;
        if (idx_q == cnt_q - 1'b1 || status_i.suppress) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (leave) begin
          cmd_o.wr_en    = keep;
          cmd_o.out_load = emit;
          cmd_o.out_keep = keep;
          cmd_o.out_last = last_q;
          if (emit) begin
            out_valid_d = 1'b1;
          end
          if (last_q) begin
            cnt_d  = '0;
            seen_d = '0;
          end else if (keep) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THR_RESET;
      pre_q       <= '0;
      post_q      <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      go_q        <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      pre_q       <= pre_d;
      post_q      <= post_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      go_q        <= go_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign thr_o       = thr_q;
  assign rd_addr_o   = idx_q[AW-1:0];
  assign wr_addr_o   = cnt_q[AW-1:0];

endmodule

// File: design/greedy_box_suppression.sv
// Greedy box suppression over score-sorted corner boxes.
// Input channel in_valid_i/in_ready_o carries one box per transaction, with
// last_box marking the final box of a set. Output channel out_valid_o/
// out_ready_i carries at most one result per box: a kept box, or an
// end-of-set marker for a last box that was not kept.
// Configuration (threshold, pre limit, post limit) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// Each box is tested against the kept list through a five-stage overlap
// pipeline fed by one kept-list memory read per cycle; the scan is skipped
// when the list is empty or the box is not considered, and it stops early
// once the box is suppressed.
// One box is processed at a time; in_ready_o returns in the cycle the result
// is loaded into the output register.
// A waiting result does not block the next box, but a box whose result
// finds the output register still full waits until the receiver takes it.
// Reset empties the list and counters and restores the register defaults;
// the list memory itself is not cleared and needs no clearing time.
module greedy_box_suppression import gbs_pkg::*; #(
  parameter int MAX_KEPT = GBS_MAX_KEPT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  gbs_cmd_t         cmd;
  gbs_status_t      status;
  logic [THR_W-1:0] thr;
  logic [AW-1:0]    rd_addr, wr_addr;

  // sequencing, counters and configuration
  gbs_ctrl #(
    .MAX_KEPT(MAX_KEPT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_last_i  (in_data_i.last_box),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .thr_o      (thr),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  // kept list and overlap arithmetic
  gbs_datapath #(
    .MAX_KEPT(MAX_KEPT)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .thr_i     (thr),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .in_data_i (in_data_i),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

`ifndef SYNTHESIS
  // a new box never enters while overlap tests are in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status.pipe_busy)
    else $error("box accepted while overlap pipeline busy");

  // a result without a kept box only marks the end of a set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.kept) |-> out_data_o.end_of_set)
    else $error("empty result outside end of set");

  // one box at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after input transaction");
`endif

endmodule
